/* rtl/core/ewh_pkg.sv */
// Package holding the shared configuration width constant for the equal-width histogram unit
`default_nettype none
package ewh_pkg;
  localparam int CFG_BITS = 7;
endpackage
`default_nettype wire

/* rtl/core/ewh_ram.sv */
// Generic single-port RAM with registered read
`default_nettype none
module ewh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/core/ewh_div.sv */
// Iterative restoring divider: quotient of num / den, one bit per cycle
`default_nettype none
module ewh_div #(
  parameter int NW = 24,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic      [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  assign trial = {rem_r, q_r[NW-1]};
  assign quo   = q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= DW'(trial - {1'b0, den_r});
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial[DW-1:0];
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/equal_width_histogram_unit.sv */
// Top level: equal-width histogram, Sturges bin rule unless cfg_data sets a bin count
//
// channel | dir | payload
// in_     | in  | in_sample, in_last_sample
// out_    | out | out_bin_index, out_bin_total, out_sample_total, out_overflow, out_last_bin
// cfg_    | in  | cfg_data (bin_count)
//
// A request that is not last is taken at once; in_ready stays high while loading.
// A last request starts a clear of all MAX_BINS count entries, then per stored sample a
// read, a divide on the shared bit-serial divider (NW = SAMPLE_BITS + 1 + $clog2(MAX_BINS+1)
// bits, 24 at defaults), skipped when min equals max, and a count read and increment; then
// a read that primes the count and one result per bin as out_ready allows. in_ready is low
// until the last result is taken. Reset is synchronous; the output register holds under stall.
`default_nettype none
module equal_width_histogram_unit
  import ewh_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_BINS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_last_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [$clog2(MAX_BINS)-1:0] out_bin_index,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] out_bin_total,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] out_sample_total,
  output logic                        out_overflow,
  output logic                        out_last_bin,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_BITS-1:0]    cfg_data
);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int BW = $clog2(MAX_BINS);
  localparam int BCW = $clog2(MAX_BINS + 1);
  localparam int DW = SAMPLE_BITS + 1;
  localparam int NW = DW + BCW;

  typedef enum logic [3:0] {
    S_LOAD, S_CLR, S_RD, S_WAIT, S_DIV, S_RDC, S_INC, S_PRE, S_EMIT
  } state_t;
  state_t state_r;

  logic [CFG_BITS-1:0] cfg_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic signed [SAMPLE_BITS-1:0] min_r, max_r;
  logic drop_r;
  logic [BCW-1:0] bins_r;
  logic [BW-1:0] bin_r;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [SAMPLE_BITS-1:0] ram_q;
  logic bc_we;
  logic [BW-1:0] bc_addr;
  logic [CW-1:0] bc_wdata, bc_q;
  logic div_start, div_done;
  logic [NW-1:0] div_quo;
  logic [DW-1:0] range_w, diff_w;
  logic [BCW-1:0] sturges, cfg_sat;
  logic [NW-1:0] qsat;
  logic [CW-1:0] nm1;

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_LOAD) && !out_valid;
  assign ram_we = in_valid && in_ready && (cnt_r < CW'(MAX_SAMPLES));
  assign ram_addr = (state_r == S_LOAD) ? cnt_r[AW-1:0] : idx_r[AW-1:0];

  ewh_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_sample), .rdata(ram_q));

  // bin count table: cleared, read-modify-write per sample, read ahead while emitting
  assign bc_we = (state_r == S_CLR) || (state_r == S_INC);
  assign bc_wdata = (state_r == S_CLR) ? '0 : bc_q + CW'(1);
  assign bc_addr = ((state_r == S_EMIT) && (!out_valid || out_ready)) ? bin_r + 1'b1 : bin_r;

  ewh_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_bins (
    .clk(clk), .we(bc_we), .addr(bc_addr), .wdata(bc_wdata), .rdata(bc_q));

  assign range_w = DW'(max_r) - DW'(min_r);
  assign diff_w  = DW'($signed(ram_q)) - DW'(min_r);
  assign div_start = (state_r == S_WAIT) && (range_w != '0);

  ewh_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(NW'(diff_w) * NW'(bins_r)), .den(range_w), .done(div_done), .quo(div_quo));

  always_comb begin
    nm1 = (cnt_r + CW'(ram_we)) - CW'(1);
    sturges = BCW'(1);
    for (int i = 0; i < CW; i++) if (nm1[i]) sturges = BCW'(i + 2);
    if (sturges > BCW'(MAX_BINS)) sturges = BCW'(MAX_BINS);
    cfg_sat = (32'(cfg_r) > MAX_BINS) ? BCW'(MAX_BINS) : BCW'(cfg_r);
    qsat = (div_quo > NW'(bins_r - 1'b1)) ? NW'(bins_r - 1'b1) : div_quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cfg_r <= '0; cnt_r <= '0; drop_r <= 1'b0;
      min_r <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_r <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) cfg_r <= cfg_data;
      case (state_r)
        S_LOAD: if (in_valid && in_ready) begin
          if (ram_we) begin
            cnt_r <= cnt_r + 1'b1;
            if ($signed(in_sample) < min_r) min_r <= in_sample;
            if ($signed(in_sample) > max_r) max_r <= in_sample;
          end else drop_r <= 1'b1;
          if (in_last_sample) begin
            bins_r <= (cfg_r == '0) ? sturges : cfg_sat;
            bin_r <= '0; state_r <= S_CLR;
          end
        end
        S_CLR: begin
          bin_r <= bin_r + 1'b1;
          if (32'(bin_r) == MAX_BINS - 1) begin idx_r <= '0; state_r <= S_RD; end
        end
        S_RD: state_r <= (idx_r == cnt_r) ? S_PRE : S_WAIT;
        S_WAIT: begin
          bin_r <= BW'(bins_r - 1'b1);
          state_r <= (range_w == '0) ? S_RDC : S_DIV;
        end
        S_DIV: if (div_done) begin bin_r <= BW'(qsat); state_r <= S_RDC; end
        S_RDC: state_r <= S_INC;
        S_INC: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r + 1'b1 == cnt_r) begin bin_r <= '0; state_r <= S_PRE; end
          else state_r <= S_RD;
        end
        S_PRE: state_r <= S_EMIT;
        S_EMIT: if (!out_valid || out_ready) begin
          if (out_valid && out_last_bin) begin
            out_valid <= 1'b0; state_r <= S_LOAD; cnt_r <= '0; drop_r <= 1'b0;
            min_r <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            max_r <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          end else begin
            out_valid <= 1'b1;
            out_bin_index <= bin_r;
            out_bin_total <= bc_q;
            out_sample_total <= cnt_r;
            out_overflow <= drop_r;
            out_last_bin <= (BCW'(bin_r) == bins_r - 1'b1);
            bin_r <= bin_r + 1'b1;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/ewh_checker.sv */
// Port-level checker for the equal-width histogram unit
`default_nettype none
module ewh_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last_bin,
  input wire logic [5:0] out_bin_index,
  input wire logic [10:0] out_bin_total,
  input wire logic [10:0] out_sample_total
);
  a_noin: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input taken while results pending");
  a_tot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bin_total <= out_sample_total) else $error("bin over total");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_bin |=> out_valid &&
    out_bin_index == $past(out_bin_index) + 6'd1) else $error("bin order");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bin_index)) else $error("stall");
endmodule
bind equal_width_histogram_unit ewh_checker u_chk (.*);
`default_nettype wire

/* test/equal_width_histogram_unit_tb.sv */
// Testbench: equal-width histogram unit, bin results checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module equal_width_histogram_unit_tb;
  import ewh_pkg::*;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_BINS    = 64;

  typedef struct {
    int unsigned bin_index;
    int unsigned bin_total;
    int unsigned sample_total;
    bit          overflow;
    bit          last_bin;
  } bin_result_t;

  class histogram_board;
    int          errors;
    int          bins_seen;
    int          sets_done;
    bit [6:0]    bin_reg;
    longint      data[$];
    longint      lo, hi;
    bit          dropped;
    bin_result_t pending_bins[$];

    function new();
      errors = 0;
      bins_seen = 0;
      sets_done = 0;
      bin_reg = 0;
      clear_set();
    endfunction

    function void clear_set();
      data.delete();
      lo = 32767;
      hi = -32768;
      dropped = 0;
    endfunction

    function int unsigned pick_bins();
      int unsigned b;
      int unsigned x;
      if (bin_reg == 0) begin
        b = 1;
        x = data.size() - 1;
        while (x != 0) begin
          b++;
          x >>= 1;
        end
      end else begin
        b = 32'(bin_reg);
      end
      if (b > MAX_BINS) b = MAX_BINS;
      return b;
    endfunction

    function void note_sample(logic signed [15:0] s, bit last);
      int unsigned b;
      int unsigned counts[MAX_BINS];
      longint range, idx;
      bin_result_t r;
      if (data.size() < MAX_SAMPLES) begin
        data.push_back(s);
        if (s < lo) lo = s;
        if (s > hi) hi = s;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      b = pick_bins();
      foreach (counts[k]) counts[k] = 0;
      range = hi - lo;
      foreach (data[i]) begin
        if (range == 0) idx = b - 1;
        else begin
          idx = ((data[i] - lo) * b) / range;
          if (idx > b - 1) idx = b - 1;
        end
        counts[idx]++;
      end
      for (int k = 0; k < b; k++) begin
        r.bin_index = k;
        r.bin_total = counts[k];
        r.sample_total = data.size();
        r.overflow = dropped;
        r.last_bin = (k == b - 1);
        pending_bins.push_back(r);
      end
      sets_done++;
      clear_set();
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task check_bin(bin_result_t got);
      bin_result_t want;
      if (pending_bins.size() == 0) begin
        report("unexpected result, bin_index", got.bin_index, 0);
        return;
      end
      want = pending_bins.pop_front();
      bins_seen++;
      if (got.bin_index != want.bin_index) report("bin_index", got.bin_index, want.bin_index);
      if (got.bin_total != want.bin_total) report("bin_total", got.bin_total, want.bin_total);
      if (got.sample_total != want.sample_total)
        report("sample_total", got.sample_total, want.sample_total);
      if (got.overflow != want.overflow) report("overflow", got.overflow, want.overflow);
      if (got.last_bin != want.last_bin) report("last_bin", got.last_bin, want.last_bin);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_sample;
  logic        in_last_sample;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_bin_index;
  logic [10:0] out_bin_total;
  logic [10:0] out_sample_total;
  logic        out_overflow;
  logic        out_last_bin;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_BITS-1:0] cfg_data;

  histogram_board board;
  bit idle_on;
  int stall_left;
  int requests;

  equal_width_histogram_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_bin_index(out_bin_index), .out_bin_total(out_bin_total),
    .out_sample_total(out_sample_total), .out_overflow(out_overflow),
    .out_last_bin(out_last_bin),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  function int draw_gap();
    return idle_on ? $urandom_range(0, 15) : 0;
  endfunction

  always @(posedge clk) begin
    bin_result_t r;
    if (rst_n && out_valid && out_ready) begin
      r.bin_index = out_bin_index;
      r.bin_total = out_bin_total;
      r.sample_total = out_sample_total;
      r.overflow = out_overflow;
      r.last_bin = out_last_bin;
      board.check_bin(r);
      stall_left = draw_gap();
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task send_sample(logic [15:0] s, bit last);
    int gap;
    in_valid <= 1'b1;
    in_sample <= s;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(s, last);
    requests++;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    in_valid <= 1'b0;
    while (board.pending_bins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_bins(logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.bin_reg = v;
  endtask

  function logic [15:0] rand_value(int mode, logic [15:0] base);
    case (mode)
      0: rand_value = 16'($urandom);
      1: rand_value = 16'(base + $urandom_range(0, 20));
      2: rand_value = base;
      default: rand_value = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  task send_set(int n, int mode);
    logic [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < n; i++) send_sample(rand_value(mode, base), i == n - 1);
  endtask

  initial begin
    int n;
    board = new();
    rst_n = 0;
    in_valid = 0;
    in_sample = 0;
    in_last_sample = 0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_data = 0;
    stall_left = 0;
    requests = 0;
    idle_on = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single sample, Sturges gives one bin
    send_sample(16'h1234, 1);
    drain();
    send_sample(16'h8000, 0);
    send_sample(16'h7fff, 0);
    send_sample(16'h0000, 0);
    send_sample(16'hffff, 1);
    write_bins(7'd127);
    send_set(4, 2);
    write_bins(7'd1);
    send_set(5, 0);
    write_bins(7'd64);
    send_sample(16'h8000, 0);
    send_sample(16'h8001, 0);
    send_sample(16'h7ffe, 0);
    send_sample(16'h7fff, 1);
    write_bins(7'd0);

    while (requests < 230) begin
      if ($urandom_range(0, 2) == 0)
        write_bins(7'($urandom_range(0, 3) == 0 ? $urandom_range(65, 127)
                                                : $urandom_range(0, 64)));
      idle_on = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      if (n > 230 - requests) n = 230 - requests;
      send_set(n, $urandom_range(0, 3));
    end

    in_valid <= 1'b0;
    while (board.pending_bins.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d samples in %0d data sets, %0d bin results checked",
             requests, board.sets_done, board.bins_seen);
    $display("bin register swept incl. 0, 1, 64 and saturating values; constant and extreme sets");
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
